// File: src/cfe_pkg.sv
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types, constants and helper functions for the cuckoo filter engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cfe_pkg;

	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int FP_W          = 8;
	localparam int XW            = (IDX_W > FP_W) ? IDX_W : FP_W;
	localparam int KICK_W        = 10;
	localparam int LFSR_W        = 32;
	localparam int HASH_W        = 64;
	localparam int REQ_W         = 2;

	localparam logic [LFSR_W-1:0] LFSR_TAPS       = 32'h8020_0003;
	localparam logic [KICK_W-1:0] MAX_KICKS_RESET = 10'd500;
	localparam logic [LFSR_W-1:0] SEED_RESET      = 32'd1;

	// request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CHECK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

	// configuration register indexes
	localparam logic CFG_MAX_KICKS = 1'b0;
	localparam logic CFG_SEED      = 1'b1;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [HASH_W-1:0] hash_value;
	} req_t;

	typedef struct packed {
		logic found;
		logic status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

	function automatic logic [FP_W-1:0] fp_of(input logic [HASH_W-1:0] h);
		logic [FP_W-1:0] f;
		f = h[15:8];
		return (f == '0) ? FP_W'(1) : f;
	endfunction

	function automatic logic [IDX_W-1:0] alt_bucket(input logic [IDX_W-1:0] b,
			input logic [FP_W-1:0] fp);
		logic [XW-1:0] x;
		x = XW'(b) ^ XW'(fp);
		return x[IDX_W-1:0];
	endfunction

	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
		return (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
	endfunction

	function automatic logic [LFSR_W-1:0] seed_load(input logic [LFSR_W-1:0] s);
		return (s != '0) ? s : LFSR_W'(1);
	endfunction

endpackage

`default_nettype wire

// File: src/cuckoo_filter_engine_top.sv
// Check, delete and unused codes pass through READ, EVAL and DONE before the response.
// Insert runs r table rounds (1 <= r <= max_kicks; one round if max_kicks is zero),
// each a read and an evaluate state on the shared table port pair and compare unit.
// One transaction is in flight at a time; the next is taken once the result is queued.
// Reset: a clearing pass over all TABLE_ENTRIES (1024) entries zeroes both tables with
// req_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// cuckoo_filter_engine_top
// Two-table cuckoo filter with 8-bit fingerprints and LFSR victim selection.
// ----------------------------------------------------------------------------
`default_nettype none

module cuckoo_filter_engine_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire cfe_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output cfe_pkg::rsp_t      rsp,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic          cfg_index,
	input  wire logic [31:0]   cfg_data
);
	import cfe_pkg::*;

	state_t state_q, state_d;

	logic [IDX_W-1:0]  clr_q;
	logic [REQ_W-1:0]  req_q;
	logic [FP_W-1:0]   fp_q;
	logic [IDX_W-1:0]  bkt_q;
	logic [KICK_W-1:0] round_q;
	logic [KICK_W-1:0] max_kicks_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic              found_q, status_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [IDX_W-1:0]  b2;
	logic [FP_W-1:0]   f1, f2;
	logic [IDX_W-1:0]  addr1, addr2;
	logic              we1, we2;
	logic [FP_W-1:0]   wd1, wd2;
	logic [LFSR_W-1:0] lfsr_nx;
	logic              hit1, hit2, free1, free2;
	logic              eval_done, eval_found, eval_status, kick, kick_second;
	logic [KICK_W-1:0] round_nx;
	logic              accept, rsp_free;

	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign b2          = alt_bucket(bkt_q, fp_q);
	assign hit1        = (f1 == fp_q);
	assign hit2        = (f2 == fp_q);
	assign free1       = (f1 == '0);
	assign free2       = (f2 == '0);
	assign lfsr_nx     = lfsr_step(lfsr_q);
	assign kick_second = lfsr_nx[0];
	assign round_nx    = round_q + KICK_W'(1);

	cfe_ram #(.WIDTH(FP_W), .DEPTH(TABLE_ENTRIES)) u_first (
		.clk   (clk),
		.we    (we1),
		.addr  (addr1),
		.wdata (wd1),
		.rdata (f1)
	);

	cfe_ram #(.WIDTH(FP_W), .DEPTH(TABLE_ENTRIES)) u_second (
		.clk   (clk),
		.we    (we2),
		.addr  (addr2),
		.wdata (wd2),
		.rdata (f2)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == IDX_W'(TABLE_ENTRIES - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_READ;
			ST_READ:  state_d = ST_EVAL;
			ST_EVAL:  state_d = eval_done ? ST_DONE : ST_READ;
			ST_DONE:  if (rsp_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs: table port control and round decision
	always_comb begin
		addr1       = bkt_q;
		addr2       = b2;
		we1         = 1'b0;
		we2         = 1'b0;
		wd1         = fp_q;
		wd2         = fp_q;
		eval_done   = 1'b0;
		eval_found  = 1'b0;
		eval_status = 1'b0;
		kick        = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				addr1 = clr_q;
				addr2 = clr_q;
				we1   = 1'b1;
				we2   = 1'b1;
				wd1   = '0;
				wd2   = '0;
			end
			ST_EVAL: begin
				eval_done = 1'b1;
				case (req_q)
					REQ_INSERT: begin
						if (max_kicks_q == '0) begin
							eval_status = 1'b1;
						end else if (free1 || hit1) begin
							we1 = 1'b1;
						end else if (free2 || hit2) begin
							we2 = 1'b1;
						end else begin
							// evict: the LFSR picks which table gives up its entry
							kick        = 1'b1;
							we1         = !kick_second;
							we2         = kick_second;
							eval_done   = (round_nx == max_kicks_q);
							eval_status = eval_done;
						end
					end
					REQ_CHECK: begin
						eval_found = hit1 || hit2;
					end
					REQ_DELETE: begin
						wd1 = '0;
						wd2 = '0;
						we1 = hit1;
						we2 = !hit1 && hit2;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			max_kicks_q <= MAX_KICKS_RESET;
			lfsr_q      <= seed_load(SEED_RESET);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAX_KICKS) begin
					max_kicks_q <= cfg_data[KICK_W-1:0];
				end else begin
					lfsr_q <= seed_load(cfg_data);
				end
			end else if (kick) begin
				lfsr_q <= lfsr_nx;
			end
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req.req_type;
			fp_q    <= fp_of(req.hash_value);
			bkt_q   <= req.hash_value[IDX_W-1:0];
			round_q <= '0;
		end
		if (kick) begin
			round_q <= round_nx;
			fp_q    <= kick_second ? f2 : f1;
			if (kick_second) begin
				bkt_q <= alt_bucket(b2, f2);
			end
		end
		if (state_q == ST_EVAL && eval_done) begin
			found_q  <= eval_found;
			status_q <= eval_status;
		end
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.found  <= found_q;
			rsp_q.status <= status_q;
		end
	end

endmodule

`default_nettype wire

// File: src/cfe_ram.sv
// ----------------------------------------------------------------------------
// cfe_ram
// Generic single-port RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

// File: src/cfe_checker.sv
// ----------------------------------------------------------------------------
// cfe_checker
// Port-level checks on the cuckoo filter engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfe_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire cfe_pkg::rsp_t rsp
);

	// one transaction at a time: no second request straight after the first
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous transaction in flight");

	// a response cannot rise during the first read and evaluate states after a request
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid) ##1 !$rose(rsp_valid))
		else $error("response earlier than the table read allows");

	// only a check sets found, only an insert overflows
	a_found_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.found && rsp.status))
		else $error("found and overflow reported together");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind cuckoo_filter_engine_top cfe_checker u_cfe_checker (.*);

`default_nettype wire
